FILE: hdl/haar_feature_from_integral_image_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Haar feature block
// Concurrent checks clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HAAR_FEATURE_FROM_INTEGRAL_IMAGE_MACROS_SVH
`define HAAR_FEATURE_FROM_INTEGRAL_IMAGE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HFI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define HFI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/haar_pkg.sv
// ----------------------------------------------------------------------------
// haar_pkg
// Field widths, stream packing offsets and register codes of the Haar
// feature evaluator.
// ----------------------------------------------------------------------------
package haar_pkg;

    // field widths
    localparam int ROW_W    = 8;
    localparam int COL_W    = 8;
    localparam int VAL_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int WEIGHT_W = 16;
    localparam int ACC_W    = 56;
    localparam int BOX_W    = 9;

    // stream packing, lowest field first
    localparam int OFS_ROW    = 0;
    localparam int OFS_COL    = OFS_ROW + ROW_W;
    localparam int OFS_VAL    = OFS_COL + COL_W;
    localparam int OFS_TOP    = OFS_VAL + VAL_W;
    localparam int OFS_LEFT   = OFS_TOP + FRAC_W;
    localparam int OFS_BOTTOM = OFS_LEFT + FRAC_W;
    localparam int OFS_RIGHT  = OFS_BOTTOM + FRAC_W;
    localparam int OFS_WEIGHT = OFS_RIGHT + FRAC_W;
    localparam int S_TDATA_W  = OFS_WEIGHT + WEIGHT_W;
    localparam int M_TDATA_W  = ACC_W;

    // op codes carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_RECT  = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH  = 2'd3;

    // coordinate arithmetic: origin*2^16 + frac*size + half
    localparam int SUM_W  = BOX_W + FRAC_W + 1;
    localparam int SCL_W  = BOX_W + FRAC_W;
    localparam int POS_W  = SUM_W - FRAC_W;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);

    // shared multiplier: signed diff x signed weight, or size x fraction
    localparam int DIFF_W  = VAL_W + 2;
    localparam int MUL_A_W = DIFF_W;
    localparam int MUL_B_W = FRAC_W + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

FILE: hdl/haar_feature_from_integral_image.sv
// Op 0 (store write): accepted while idle, written at the accept edge.
// Op 1 (rectangle): the sequencer runs scale, read, weight multiply, accumulate;
//   a last rectangle's result is registered from accumulate, which waits while
//   the output is full. No item is taken until idle: the shared multiplier and
//   single-port store (four reads) are in use. Sync active-low reset clears the
//   sequencer, accumulator, flag, output valid, box sizes; origins to 1; no store clear.
`include "haar_feature_from_integral_image_macros.svh"
// ----------------------------------------------------------------------------
// haar_feature_from_integral_image
// Haar-like rectangle evaluator over a stored integral image, using one
// shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
module haar_feature_from_integral_image #(
    parameter int IMG_ROWS = 256,
    parameter int IMG_COLS = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [haar_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [haar_pkg::BOX_W-1:0]           i_cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // write_row, write_col, write_value, top_frac, left_frac, bottom_frac,
    // right_frac, rect_weight
    input  logic [haar_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tuser,  // op
    input  logic                                 s_axis_tlast,  // last_rect
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [haar_pkg::M_TDATA_W-1:0]       m_axis_tdata,  // feature_value
    output logic                                 m_axis_tuser   // out_of_range
);
    import haar_pkg::*;

    localparam int RW    = $clog2(IMG_ROWS);
    localparam int CW    = $clog2(IMG_COLS);
    localparam int DEPTH = IMG_ROWS * IMG_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int MAXD  = (IMG_ROWS > IMG_COLS) ? IMG_ROWS : IMG_COLS;
    localparam int LW    = $clog2(MAXD + 1);
    localparam int XW    = (LW > POS_W) ? LW : POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCALE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WMUL  = 3'd3;
    localparam logic [2:0] S_ACC   = 3'd4;

    localparam logic [2:0] CNT_LAST = 3'd4;

    // control
    logic [2:0]        r_state, n_state;
    logic [2:0]        r_cnt, n_cnt;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic              r_clamp_seen, n_clamp_seen;
    logic              r_out_valid, n_out_valid;
    logic [BOX_W-1:0]  r_box_top, r_box_left, r_box_height, r_box_width;

    // payload
    logic [FRAC_W-1:0]         r_top_frac, r_left_frac, r_bot_frac, r_right_frac;
    logic [WEIGHT_W-1:0]       r_weight;
    logic                      r_last;
    logic signed [MUL_P_W-1:0] r_prod, n_prod;
    logic [RW-1:0]             r_ht, n_ht, r_hb, n_hb;
    logic [CW-1:0]             r_wl, n_wl, r_wr, n_wr;
    logic                      r_item_clamp, n_item_clamp;
    logic signed [DIFF_W-1:0]  r_diff, n_diff;
    logic [ACC_W-1:0]          r_out_data, n_out_data;
    logic                      r_out_flag, n_out_flag;

    // store
    logic [VAL_W-1:0] r_mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;
    logic [AW-1:0]    mem_addr;
    logic             mem_we;

    logic             in_accept, out_free;
    logic [XW-1:0]    w_row_x, w_col_x;
    logic [AW-1:0]    w_addr, rd_addr;
    logic [RW-1:0]    rd_row;
    logic [CW-1:0]    rd_col;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic [FRAC_W-1:0]         sel_frac;
    logic [BOX_W-1:0]          sel_size, sel_origin;
    logic [1:0]                k_cor;
    logic                      cor_is_row;
    logic [SUM_W-1:0]          t_sum;
    logic [XW-1:0]             pos_x, lim_x, cor_x;
    logic                      cor_clamp;
    logic signed [DIFF_W-1:0]  rd_ext;
    logic [ACC_W-1:0]          acc_sum;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_flag;

    // store addressing: input write address while idle, corner reads after
    assign w_row_x = XW'(s_axis_tdata[OFS_ROW +: ROW_W]);
    assign w_col_x = XW'(s_axis_tdata[OFS_COL +: COL_W]);
    assign w_addr  = AW'(w_row_x[RW-1:0]) * AW'(IMG_COLS) + AW'(w_col_x[CW-1:0]);
    assign mem_we  = in_accept && (s_axis_tuser == OP_WRITE)
                     && (w_row_x < XW'(IMG_ROWS)) && (w_col_x < XW'(IMG_COLS));

    always_comb begin
        case (r_cnt[1:0])
            2'd0: begin
                rd_row = r_ht;
                rd_col = r_wl;
            end
            2'd1: begin
                rd_row = r_hb;
                rd_col = r_wr;
            end
            2'd2: begin
                rd_row = r_ht;
                rd_col = r_wr;
            end
            default: begin
                rd_row = r_hb;
                rd_col = r_wl;
            end
        endcase
    end

    assign rd_addr  = AW'(rd_row) * AW'(IMG_COLS) + AW'(rd_col);
    assign mem_addr = (r_state == S_IDLE) ? w_addr : rd_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= s_axis_tdata[OFS_VAL +: VAL_W];
        end
        r_rdata <= r_mem[mem_addr];
    end

    // shared multiplier operands
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    sel_frac = r_top_frac;
            2'd1:    sel_frac = r_left_frac;
            2'd2:    sel_frac = r_bot_frac;
            default: sel_frac = r_right_frac;
        endcase
        sel_size = r_cnt[0] ? r_box_width : r_box_height;
        if (r_state == S_SCALE) begin
            mul_a = $signed({{(MUL_A_W-BOX_W){1'b0}}, sel_size});
            mul_b = $signed({1'b0, sel_frac});
        end else begin
            mul_a = r_diff;
            mul_b = $signed({r_weight[WEIGHT_W-1], r_weight});
        end
    end

    assign mul_p = mul_a * mul_b;

    // corner from the scaled fraction registered in r_prod
    assign k_cor      = r_cnt[1:0] - 2'd1;
    assign cor_is_row = !k_cor[0];
    assign sel_origin = cor_is_row ? r_box_top : r_box_left;
    assign t_sum      = SUM_W'({sel_origin, {FRAC_W{1'b0}}}) + SUM_W'(r_prod[SCL_W-1:0])
                        + ROUND_HALF;
    assign pos_x      = XW'(t_sum[SUM_W-1:FRAC_W]);
    assign lim_x      = cor_is_row ? XW'(IMG_ROWS) : XW'(IMG_COLS);

    always_comb begin
        if (pos_x == '0) begin
            cor_x     = '0;
            cor_clamp = 1'b1;
        end else if (pos_x > lim_x) begin
            cor_x     = lim_x - XW'(1);
            cor_clamp = 1'b1;
        end else begin
            cor_x     = pos_x - XW'(1);
            cor_clamp = 1'b0;
        end
    end

    assign rd_ext  = $signed({{(DIFF_W-VAL_W){1'b0}}, r_rdata});
    assign acc_sum = r_acc + {{(ACC_W-MUL_P_W){r_prod[MUL_P_W-1]}}, r_prod};

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_acc        = r_acc;
        n_clamp_seen = r_clamp_seen;
        n_out_valid  = r_out_valid;
        n_prod       = r_prod;
        n_ht         = r_ht;
        n_hb         = r_hb;
        n_wl         = r_wl;
        n_wr         = r_wr;
        n_item_clamp = r_item_clamp;
        n_diff       = r_diff;
        n_out_data   = r_out_data;
        n_out_flag   = r_out_flag;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_accept && (s_axis_tuser == OP_RECT)) begin
                    n_state      = S_SCALE;
                    n_cnt        = '0;
                    n_item_clamp = 1'b0;
                end
            end
            S_SCALE: begin
                n_prod = mul_p;
                if (r_cnt != '0) begin
                    n_item_clamp = r_item_clamp | cor_clamp;
                    case (k_cor)
                        2'd0:    n_ht = cor_x[RW-1:0];
                        2'd1:    n_wl = cor_x[CW-1:0];
                        2'd2:    n_hb = cor_x[RW-1:0];
                        default: n_wr = cor_x[CW-1:0];
                    endcase
                end
                if (r_cnt == CNT_LAST) begin
                    n_state = S_READ;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_READ: begin
                // data of the read issued last cycle: +TL, +BR, -TR, -BL
                case (r_cnt)
                    3'd0:    n_diff = r_diff;
                    3'd1:    n_diff = rd_ext;
                    3'd2:    n_diff = r_diff + rd_ext;
                    default: n_diff = r_diff - rd_ext;
                endcase
                if (r_cnt == CNT_LAST) begin
                    n_state = S_WMUL;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_WMUL: begin
                n_prod  = mul_p;
                n_state = S_ACC;
            end
            S_ACC: begin
                if (!r_last) begin
                    n_acc        = acc_sum;
                    n_clamp_seen = r_clamp_seen | r_item_clamp;
                    n_state      = S_IDLE;
                end else if (out_free) begin
                    n_out_data   = acc_sum;
                    n_out_flag   = r_clamp_seen | r_item_clamp;
                    n_out_valid  = 1'b1;
                    n_acc        = '0;
                    n_clamp_seen = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_acc        <= '0;
            r_clamp_seen <= 1'b0;
            r_out_valid  <= 1'b0;
            r_box_top    <= BOX_W'(1);
            r_box_left   <= BOX_W'(1);
            r_box_height <= '0;
            r_box_width  <= '0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_acc        <= n_acc;
            r_clamp_seen <= n_clamp_seen;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BOX_TOP:    r_box_top    <= i_cfg_data;
                    CFG_BOX_LEFT:   r_box_left   <= i_cfg_data;
                    CFG_BOX_HEIGHT: r_box_height <= i_cfg_data;
                    CFG_BOX_WIDTH:  r_box_width  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_top_frac   <= s_axis_tdata[OFS_TOP +: FRAC_W];
            r_left_frac  <= s_axis_tdata[OFS_LEFT +: FRAC_W];
            r_bot_frac   <= s_axis_tdata[OFS_BOTTOM +: FRAC_W];
            r_right_frac <= s_axis_tdata[OFS_RIGHT +: FRAC_W];
            r_weight     <= s_axis_tdata[OFS_WEIGHT +: WEIGHT_W];
            r_last       <= s_axis_tlast;
        end
        r_prod       <= n_prod;
        r_ht         <= n_ht;
        r_hb         <= n_hb;
        r_wl         <= n_wl;
        r_wr         <= n_wr;
        r_item_clamp <= n_item_clamp;
        r_diff       <= n_diff;
        r_out_data   <= n_out_data;
        r_out_flag   <= n_out_flag;
    end

    `HFI_ASSERT_NEXT(a_rect_starts_scale, in_accept && (s_axis_tuser == OP_RECT),
        (r_state == S_SCALE) && (r_cnt == '0), "rectangle accept did not start scaling")
    `HFI_ASSERT_NEXT(a_emit_sets_valid, (r_state == S_ACC) && r_last && out_free,
        r_out_valid && (r_acc == '0) && !r_clamp_seen, "emit did not raise valid")
    `HFI_ASSERT_NEXT(a_stall_holds_acc, (r_state == S_ACC) && r_last && !out_free,
        (r_state == S_ACC) && $stable(r_acc), "stalled emit changed the accumulator")
    `HFI_ASSERT_SAME(a_cnt_bound, 1'b1, r_cnt <= CNT_LAST, "step counter out of range")
    `HFI_ASSERT_SAME(a_no_write_busy, r_state != S_IDLE, !mem_we, "store written while busy")

endmodule

FILE: test/haar_feature_from_integral_image_test.sv
// ----------------------------------------------------------------------------
// haar_feature_from_integral_image_test
// Self-checking bench for the Haar feature evaluator. Fills integral image
// entries, streams rectangle terms under several box settings and compares
// each feature sum and out-of-range flag with a transaction-level predictor.
// ----------------------------------------------------------------------------
module haar_feature_from_integral_image_test;
    timeunit 1ns;
    timeprecision 1ps;

    import haar_pkg::*;

    localparam int IMG_ROWS     = 256;
    localparam int IMG_COLS     = 256;
    localparam int DRAIN_CYCLES = 24;    // long enough for an accepted rectangle to finish
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 1700;
    localparam int PHASE_ITEMS  = 240;
    localparam int WRAP_TERMS   = 140;   // enough most-negative-weight terms to wrap 56 bits

    typedef struct {
        logic                       op;
        logic [ROW_W-1:0]           write_row;
        logic [COL_W-1:0]           write_col;
        logic [VAL_W-1:0]           write_value;
        logic [FRAC_W-1:0]          top_frac;
        logic [FRAC_W-1:0]          left_frac;
        logic [FRAC_W-1:0]          bottom_frac;
        logic [FRAC_W-1:0]          right_frac;
        logic signed [WEIGHT_W-1:0] rect_weight;
        logic                       last_rect;
    } haar_item_t;

    typedef struct {
        logic [ACC_W-1:0] value;
        logic             out_of_range;
    } feature_t;

    class feature_scoreboard;
        logic [VAL_W-1:0] img [IMG_ROWS*IMG_COLS];
        logic [ACC_W-1:0] acc = '0;
        bit               clamp_seen = 1'b0;
        int unsigned      box_top = 1;
        int unsigned      box_left = 1;
        int unsigned      box_height = 0;
        int unsigned      box_width = 0;
        feature_t         pending_features[$];
        int               errors = 0;

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [BOX_W-1:0] value);
            case (idx)
                CFG_BOX_TOP:    box_top = value;
                CFG_BOX_LEFT:   box_left = value;
                CFG_BOX_HEIGHT: box_height = value;
                CFG_BOX_WIDTH:  box_width = value;
                default: ;
            endcase
        endfunction

        // scaled, rounded half up, 1-based origin added, then made 0-based and clamped
        function int unsigned corner_index(int unsigned origin, int unsigned frac,
                                           int unsigned size, int unsigned limit,
                                           inout bit clamped);
            int unsigned pos;
            pos = ((origin << FRAC_W) + frac * size + (1 << (FRAC_W - 1))) >> FRAC_W;
            if (pos == 0) begin
                clamped = 1'b1;
                return 0;
            end
            if (pos - 1 > limit - 1) begin
                clamped = 1'b1;
                return limit - 1;
            end
            return pos - 1;
        endfunction

        function longint entry(int unsigned r, int unsigned c);
            return longint'(img[r * IMG_COLS + c]);
        endfunction

        function void note_item(haar_item_t it);
            int unsigned tr, lc, br, rc;
            bit          clamped;
            longint      diff;
            longint      prod;
            feature_t    f;
            clamped = 1'b0;
            if (it.op == OP_WRITE) begin
                img[int'(it.write_row) * IMG_COLS + int'(it.write_col)] = it.write_value;
                return;
            end
            tr = corner_index(box_top, it.top_frac, box_height, IMG_ROWS, clamped);
            lc = corner_index(box_left, it.left_frac, box_width, IMG_COLS, clamped);
            br = corner_index(box_top, it.bottom_frac, box_height, IMG_ROWS, clamped);
            rc = corner_index(box_left, it.right_frac, box_width, IMG_COLS, clamped);
            diff = entry(tr, lc) + entry(br, rc) - entry(tr, rc) - entry(br, lc);
            prod = diff * longint'(it.rect_weight);
            acc = acc + prod[ACC_W-1:0];
            clamp_seen = clamp_seen | clamped;
            if (it.last_rect) begin
                f.value = acc;
                f.out_of_range = clamp_seen;
                pending_features.push_back(f);
                acc = '0;
                clamp_seen = 1'b0;
            end
        endfunction

        function void check_feature(logic [ACC_W-1:0] value, logic out_of_range);
            feature_t want;
            if (pending_features.size() == 0) begin
                errors++;
                $display("%0t: unexpected feature, expected none, got value %h flag %b",
                         $time, value, out_of_range);
                return;
            end
            want = pending_features.pop_front();
            if (value !== want.value) begin
                errors++;
                $display("%0t: feature_value expected %h got %h", $time, want.value, value);
            end
            if (out_of_range !== want.out_of_range) begin
                errors++;
                $display("%0t: out_of_range expected %b got %b",
                         $time, want.out_of_range, out_of_range);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [BOX_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // write_row, write_col, write_value, top_frac, left_frac, bottom_frac,
    // right_frac, rect_weight
    logic [S_TDATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tuser;   // op
    logic                   s_axis_tlast;   // last_rect
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;   // feature_value
    logic                   m_axis_tuser;   // out_of_range

    feature_scoreboard sb = new;
    bit                img_planned [IMG_ROWS*IMG_COLS];
    int unsigned       burst_left = 0;
    int                items_sent = 0;
    int                results_seen = 0;

    haar_feature_from_integral_image #(
        .IMG_ROWS(IMG_ROWS),
        .IMG_COLS(IMG_COLS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [S_TDATA_W-1:0] pack_tdata(haar_item_t it);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[OFS_ROW    +: ROW_W]    = it.write_row;
        d[OFS_COL    +: COL_W]    = it.write_col;
        d[OFS_VAL    +: VAL_W]    = it.write_value;
        d[OFS_TOP    +: FRAC_W]   = it.top_frac;
        d[OFS_LEFT   +: FRAC_W]   = it.left_frac;
        d[OFS_BOTTOM +: FRAC_W]   = it.bottom_frac;
        d[OFS_RIGHT  +: FRAC_W]   = it.right_frac;
        d[OFS_WEIGHT +: WEIGHT_W] = it.rect_weight;
        return d;
    endfunction

    function automatic haar_item_t unpack_item(logic op, logic last,
                                               logic [S_TDATA_W-1:0] d);
        haar_item_t it;
        it.op          = op;
        it.last_rect   = last;
        it.write_row   = d[OFS_ROW    +: ROW_W];
        it.write_col   = d[OFS_COL    +: COL_W];
        it.write_value = d[OFS_VAL    +: VAL_W];
        it.top_frac    = d[OFS_TOP    +: FRAC_W];
        it.left_frac   = d[OFS_LEFT   +: FRAC_W];
        it.bottom_frac = d[OFS_BOTTOM +: FRAC_W];
        it.right_frac  = d[OFS_RIGHT  +: FRAC_W];
        it.rect_weight = d[OFS_WEIGHT +: WEIGHT_W];
        return it;
    endfunction

    // unused fields still carry random bits
    function automatic haar_item_t random_item();
        haar_item_t it;
        it.op          = OP_RECT;
        it.write_row   = ROW_W'($urandom());
        it.write_col   = COL_W'($urandom());
        it.write_value = $urandom();
        it.top_frac    = FRAC_W'($urandom());
        it.left_frac   = FRAC_W'($urandom());
        it.bottom_frac = FRAC_W'($urandom());
        it.right_frac  = FRAC_W'($urandom());
        it.rect_weight = WEIGHT_W'($urandom());
        it.last_rect   = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic logic [FRAC_W-1:0] rand_frac();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return FRAC_W'(1) << (FRAC_W - 1);
            default: return FRAC_W'($urandom());
        endcase
    endfunction

    function automatic int unsigned rand_origin();
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return 256;
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    function automatic int unsigned rand_size();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 256;
            default: return $urandom_range(0, 256);
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic drive_item(haar_item_t it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_tdata(it);
        s_axis_tuser  <= it.op;
        s_axis_tlast  <= it.last_rect;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_write(int unsigned row, int unsigned col, logic [VAL_W-1:0] value);
        haar_item_t it;
        it = random_item();
        it.op          = OP_WRITE;
        it.write_row   = ROW_W'(row);
        it.write_col   = COL_W'(col);
        it.write_value = value;
        img_planned[row * IMG_COLS + col] = 1'b1;
        drive_item(it);
    endtask

    task automatic fill_corner(int unsigned row, int unsigned col);
        if (!img_planned[row * IMG_COLS + col])
            send_write(row, col, $urandom());
    endtask

    // every corner the term reads gets written first
    task automatic send_rect(logic [FRAC_W-1:0] top_f, logic [FRAC_W-1:0] left_f,
                             logic [FRAC_W-1:0] bottom_f, logic [FRAC_W-1:0] right_f,
                             logic signed [WEIGHT_W-1:0] weight, logic last);
        haar_item_t  it;
        int unsigned tr, lc, br, rc;
        bit          scratch;
        scratch = 1'b0;
        tr = sb.corner_index(sb.box_top, top_f, sb.box_height, IMG_ROWS, scratch);
        lc = sb.corner_index(sb.box_left, left_f, sb.box_width, IMG_COLS, scratch);
        br = sb.corner_index(sb.box_top, bottom_f, sb.box_height, IMG_ROWS, scratch);
        rc = sb.corner_index(sb.box_left, right_f, sb.box_width, IMG_COLS, scratch);
        fill_corner(tr, lc);
        fill_corner(br, rc);
        fill_corner(tr, rc);
        fill_corner(br, lc);
        it = random_item();
        it.op          = OP_RECT;
        it.top_frac    = top_f;
        it.left_frac   = left_f;
        it.bottom_frac = bottom_f;
        it.right_frac  = right_f;
        it.rect_weight = weight;
        it.last_rect   = last;
        drive_item(it);
    endtask

    task automatic send_random();
        if ($urandom_range(0, 4) == 0)
            send_write($urandom_range(0, IMG_ROWS - 1), $urandom_range(0, IMG_COLS - 1),
                       $urandom());
        else
            send_rect(rand_frac(), rand_frac(), rand_frac(), rand_frac(),
                      WEIGHT_W'($urandom()), $urandom_range(0, 3) == 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BOX_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        sb.set_register(idx, value);
        @(negedge i_clk);
    endtask

    task automatic write_box(int unsigned top_v, int unsigned left_v,
                             int unsigned height_v, int unsigned width_v);
        write_reg(CFG_BOX_TOP, BOX_W'(top_v));
        write_reg(CFG_BOX_LEFT, BOX_W'(left_v));
        write_reg(CFG_BOX_HEIGHT, BOX_W'(height_v));
        write_reg(CFG_BOX_WIDTH, BOX_W'(width_v));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // drain all features, then let any trailing non-last term finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending_features.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_item(unpack_item(s_axis_tuser, s_axis_tlast, s_axis_tdata));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_feature(m_axis_tdata, m_axis_tuser);
            results_seen++;
        end
    end

    initial begin : result_sink
        int unsigned seg;
        int unsigned pct;
        bit          held;
        m_axis_tready = 1'b0;
        held = 1'b0;
        forever begin
            pct = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(10, 90);
            seg = $urandom_range(4, 80);
            repeat (seg) begin
                @(negedge i_clk);
                // one long hold so the block backs up into its input
                if (!held && results_seen >= 40) begin
                    held = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge i_clk);
                end
                m_axis_tready <= ($urandom_range(1, 100) <= pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int n;
        int stop_at;
        int phase_end;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_WRITE;
        s_axis_tlast  = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // box registers at reset: every corner lands on entry (0,0)
        send_write(0, 0, '1);
        send_rect('0, '0, '0, '0, 16'sh7FFF, 1'b0);
        send_rect('1, '1, '1, '1, 16'sh8000, 1'b1);

        settle();
        write_box(1, 1, 256, 256);
        send_write(IMG_ROWS - 1, IMG_COLS - 1, '0);
        send_rect('0, '0, '1, '1, 16'sh7FFF, 1'b0);   // bottom/right past the image
        send_rect('0, '0, 16'h8000, 16'h8000, 16'sh8000, 1'b1);

        settle();
        write_box(256, 256, 256, 256);
        send_rect('1, '1, '1, '1, 16'sh1000, 1'b0);
        send_rect('0, '0, '0, '0, 16'sh1000, 1'b1);   // flag sticks from the first term
        send_rect('0, '0, '0, '0, 16'sh1000, 1'b1);   // and is clear for the next feature

        settle();
        write_box(1, 1, 1, 1);
        // exactly half rounds up, just below half rounds down
        send_rect(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'shF000, 1'b1);

        // largest corner difference at most negative weight, long enough to wrap
        settle();
        write_box(1, 1, 256, 256);
        send_write(0, 0, '1);
        send_write(128, 128, '1);
        send_write(0, 128, '0);
        send_write(128, 0, '0);
        for (n = 0; n < WRAP_TERMS; n++)
            send_rect('0, '0, 16'h8000, 16'h8000, 16'sh8000, n == WRAP_TERMS - 1);

        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            settle();
            write_box(rand_origin(), rand_origin(), rand_size(), rand_size());
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < stop_at)
                send_random();
        end

        settle();
        if (sb.errors == 0 && sb.pending_features.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/haar_pkg.sv
hdl/haar_feature_from_integral_image.sv
test/haar_feature_from_integral_image_test.sv
